### rtl/aqia_pkg.sv
// Shared types, constants and breakpoint tables of the air quality index averager.
// No dependencies; every other file of the block refers to this package by scoped names.
package aqia_pkg;

  localparam int SUM_W   = 21;
  localparam int DVD_W   = 26;
  localparam int DVS_W   = 17;
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 13;
  localparam int ROW_W   = 3;
  localparam int MAX_ROWS = 8;
  localparam int TAB_ROWS = 6;
  localparam int NUM_CH  = 7;
  localparam int NUM_IDX = 5;

  // Channel order of the sums and averages.
  localparam logic [2:0] CH_PM1  = 3'd0;
  localparam logic [2:0] CH_PM25 = 3'd1;
  localparam logic [2:0] CH_PM4  = 3'd2;
  localparam logic [2:0] CH_PM10 = 3'd3;
  localparam logic [2:0] CH_VOC  = 3'd4;
  localparam logic [2:0] CH_TEMP = 3'd5;
  localparam logic [2:0] CH_HUM  = 3'd6;

  // Steps of the result sequence: seven averages, then five sub-indices.
  localparam logic [3:0] STEP_FIRST_IDX = 4'd7;
  localparam logic [3:0] STEP_LAST      = 4'd11;

  localparam logic [15:0] PM_LIMIT    = 16'd15000;
  localparam logic [15:0] HUM_LIMIT   = 16'd10000;
  localparam logic signed [15:0] TEMP_HI = 16'sd20000;
  localparam logic signed [15:0] TEMP_LO = -16'sd8000;

  localparam logic [4:0] WINDOW_RESET = 5'd2;
  localparam logic [IDX_W-1:0] INDEX_MAX = 13'd8191;

  localparam logic [2:0] CAT_GOOD      = 3'd0;
  localparam logic [2:0] CAT_MODERATE  = 3'd1;
  localparam logic [2:0] CAT_SENSITIVE = 3'd2;
  localparam logic [2:0] CAT_UNHEALTHY = 3'd3;
  localparam logic [2:0] CAT_VERY      = 3'd4;
  localparam logic [2:0] CAT_HAZARD    = 3'd5;

  typedef struct packed {
    logic [16:0] clo;
    logic [16:0] chi;
    logic [8:0]  ilo;
    logic [8:0]  ihi;
  } seg_t;

  localparam seg_t SEG_TAB [NUM_IDX][TAB_ROWS] = '{
    '{'{17'd0, 17'd80, 9'd0, 9'd50}, '{17'd81, 17'd254, 9'd51, 9'd100},
      '{17'd255, 17'd354, 9'd101, 9'd150}, '{17'd355, 17'd504, 9'd151, 9'd200},
      '{17'd505, 17'd754, 9'd201, 9'd300}, '{17'd755, 17'd5004, 9'd301, 9'd500}},
    '{'{17'd0, 17'd120, 9'd0, 9'd50}, '{17'd121, 17'd354, 9'd51, 9'd100},
      '{17'd355, 17'd554, 9'd101, 9'd150}, '{17'd555, 17'd1504, 9'd151, 9'd200},
      '{17'd1505, 17'd2504, 9'd201, 9'd300}, '{17'd2505, 17'd5004, 9'd301, 9'd500}},
    '{'{17'd0, 17'd350, 9'd0, 9'd50}, '{17'd351, 17'd754, 9'd51, 9'd100},
      '{17'd755, 17'd1254, 9'd101, 9'd150}, '{17'd1255, 17'd1754, 9'd151, 9'd200},
      '{17'd1755, 17'd2504, 9'd201, 9'd300}, '{17'd2505, 17'd5004, 9'd301, 9'd500}},
    '{'{17'd0, 17'd540, 9'd0, 9'd50}, '{17'd550, 17'd1540, 9'd51, 9'd100},
      '{17'd1550, 17'd2540, 9'd101, 9'd150}, '{17'd2550, 17'd3540, 9'd151, 9'd200},
      '{17'd3550, 17'd4240, 9'd201, 9'd300}, '{17'd4250, 17'd6040, 9'd301, 9'd500}},
    '{'{17'd0, 17'd3000, 9'd0, 9'd50}, '{17'd3000, 17'd5000, 9'd51, 9'd100},
      '{17'd5000, 17'd10000, 9'd101, 9'd150}, '{17'd10000, 17'd30000, 9'd151, 9'd200},
      '{17'd40000, 17'd50000, 9'd201, 9'd300}, '{17'd50000, 17'd100000, 9'd301, 9'd500}}
  };

  // Rows past the sixth repeat the last row of the table.
  function automatic seg_t seg_lookup(input logic [2:0] ch, input logic [ROW_W-1:0] row);
    logic [ROW_W-1:0] r;
    r = (row >= ROW_W'(TAB_ROWS)) ? ROW_W'(TAB_ROWS - 1) : row;
    return SEG_TAB[ch][r];
  endfunction

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_IDX_PREP,
    S_OUT
  } aqia_state_t;

  typedef struct packed {
    logic       accum;
    logic       div_start;
    logic       div_store;
    logic       idx_prep;
    logic       out_load;
    logic [3:0] step;
  } aqia_cmd_t;

  typedef struct packed {
    logic trigger;
    logic div_done;
    logic out_free;
  } aqia_sts_t;

endpackage

### rtl/aqia_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on aqia_pkg for operand widths.
module aqia_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [aqia_pkg::DVD_W-1:0] dividend,
  input  logic [aqia_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [aqia_pkg::DVD_W-1:0] quotient,
  output logic [aqia_pkg::DVS_W-1:0] remainder
);

  localparam int DVD_W = aqia_pkg::DVD_W;
  localparam int DVS_W = aqia_pkg::DVS_W;
  localparam int BIT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   trial;

  always_comb begin
    rem_sh   = {rem_r, q_r[DVD_W-1]};
    trial    = rem_sh - {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      bit_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = trial[DVS_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DVS_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      bit_nxt = bit_r + 1'b1;
      if (bit_r == BIT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      bit_r  <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

### rtl/aqia_datapath.sv
// Datapath: window sums, plausibility check, averages, sub-index arithmetic and output registers.
// Depends on aqia_pkg and aqia_div.
module aqia_datapath #(
  parameter int NUM_SEGMENTS = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  aqia_pkg::aqia_cmd_t       cmd,
  output aqia_pkg::aqia_sts_t       sts,
  input  logic                      cfg_wr_en,
  input  logic [4:0]                cfg_wr_data,
  input  logic [15:0]               in_pm1_raw,
  input  logic [15:0]               in_pm25_raw,
  input  logic [15:0]               in_pm4_raw,
  input  logic [15:0]               in_pm10_raw,
  input  logic [15:0]               in_humidity_raw,
  input  logic signed [15:0]        in_temperature_raw,
  input  logic [15:0]               in_voc_raw,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [12:0]               out_index_pm1,
  output logic [12:0]               out_index_pm25,
  output logic [12:0]               out_index_pm4,
  output logic [12:0]               out_index_pm10,
  output logic [12:0]               out_index_voc,
  output logic [12:0]               out_overall_index,
  output logic [2:0]                out_category,
  output logic [15:0]               out_avg_pm25,
  output logic [15:0]               out_avg_pm10,
  output logic [15:0]               out_avg_voc,
  output logic signed [15:0]        out_avg_temperature,
  output logic [13:0]               out_avg_humidity
);

  localparam int SUM_W = aqia_pkg::SUM_W;
  localparam int DVD_W = aqia_pkg::DVD_W;
  localparam int DVS_W = aqia_pkg::DVS_W;
  localparam int IDX_W = aqia_pkg::IDX_W;
  localparam int ROW_W = aqia_pkg::ROW_W;
  localparam int ROWS_USED = (NUM_SEGMENTS > aqia_pkg::MAX_ROWS) ? aqia_pkg::MAX_ROWS :
                             (NUM_SEGMENTS < 1) ? 1 : NUM_SEGMENTS;

  logic [SUM_W-1:0] sum_r [aqia_pkg::NUM_CH];
  logic [4:0]       count_r;
  logic [4:0]       window_r;
  logic [15:0]      avg_r [aqia_pkg::NUM_CH];
  logic [IDX_W-1:0] idx_r [aqia_pkg::NUM_IDX];
  logic signed [27:0] num_r;
  logic [DVS_W-1:0] den_r;
  logic [8:0]       ilo_r;
  logic             neg_r;
  logic             out_valid_r;

  logic             plausible;
  logic [4:0]       count_inc;
  logic [SUM_W-1:0] add_val [aqia_pkg::NUM_CH];

  // Accumulation and plausibility.
  always_comb begin
    plausible = (in_pm1_raw <= aqia_pkg::PM_LIMIT) && (in_pm25_raw <= aqia_pkg::PM_LIMIT) &&
                (in_temperature_raw <= aqia_pkg::TEMP_HI) &&
                (in_temperature_raw >= aqia_pkg::TEMP_LO) &&
                (in_humidity_raw <= aqia_pkg::HUM_LIMIT);
    count_inc = count_r + 5'd1;
    add_val[aqia_pkg::CH_PM1]  = {5'b0, in_pm1_raw};
    add_val[aqia_pkg::CH_PM25] = {5'b0, in_pm25_raw};
    add_val[aqia_pkg::CH_PM4]  = {5'b0, in_pm4_raw};
    add_val[aqia_pkg::CH_PM10] = {5'b0, in_pm10_raw};
    add_val[aqia_pkg::CH_VOC]  = {5'b0, in_voc_raw};
    add_val[aqia_pkg::CH_TEMP] = {{5{in_temperature_raw[15]}}, in_temperature_raw};
    add_val[aqia_pkg::CH_HUM]  = {5'b0, in_humidity_raw};
  end

  assign sts.trigger = plausible && ((count_inc == 5'd0) || (count_inc >= window_r));

  // Divider operand selection.
  logic             avg_step;
  logic [2:0]       ch_sel;
  logic [2:0]       idx_sel;
  logic [SUM_W-1:0] sum_sel;
  logic             sum_neg;
  logic [SUM_W-1:0] sum_mag;
  logic [27:0]      num_mag;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic             dvd_neg;
  logic             div_done;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;

  always_comb begin
    avg_step = cmd.step < aqia_pkg::STEP_FIRST_IDX;
    ch_sel   = cmd.step[2:0];
    idx_sel  = 3'(cmd.step - aqia_pkg::STEP_FIRST_IDX);
    sum_sel  = sum_r[ch_sel];
    sum_neg  = (ch_sel == aqia_pkg::CH_TEMP) && sum_sel[SUM_W-1];
    sum_mag  = sum_neg ? (~sum_sel + 1'b1) : sum_sel;
    num_mag  = num_r[27] ? 28'(-num_r) : 28'(num_r);
    if (avg_step) begin
      dvd     = DVD_W'(sum_mag);
      dvs     = (count_r == 5'd0) ? DVS_W'(32) : DVS_W'(count_r);
      dvd_neg = sum_neg;
    end else begin
      dvd     = num_mag[DVD_W-1:0];
      dvs     = den_r;
      dvd_neg = num_r[27];
    end
  end

  aqia_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  assign sts.div_done = div_done;

  // Segment search and numerator of the interpolation.
  logic [15:0]        c_val;
  logic [ROW_W-1:0]   row_k;
  aqia_pkg::seg_t     seg;
  logic signed [17:0] diff;
  logic signed [9:0]  span_i;
  logic signed [27:0] prod;
  logic [15:0]        span_c;

  always_comb begin
    c_val = avg_r[idx_sel];
    row_k = ROW_W'(ROWS_USED - 1);
    for (int r = aqia_pkg::MAX_ROWS - 1; r >= 0; r--) begin
      if (r < ROWS_USED &&
          {1'b0, c_val} <= aqia_pkg::seg_lookup(idx_sel, ROW_W'(r)).chi) begin
        row_k = ROW_W'(r);
      end
    end
    seg    = aqia_pkg::seg_lookup(idx_sel, row_k);
    // Every table segment has a positive width.
    span_c = 16'(seg.chi - seg.clo);
    diff   = $signed({2'b00, c_val}) - $signed({1'b0, seg.clo});
    span_i = $signed({1'b0, seg.ihi}) - $signed({1'b0, seg.ilo});
    prod   = diff * span_i;
  end

  // Result of a division step.
  logic [15:0]        avg_res;
  logic signed [27:0] q_signed;
  logic signed [27:0] idx_sum;
  logic [IDX_W-1:0]   idx_res;

  always_comb begin
    avg_res  = neg_r ? 16'(~quo[15:0] + 1'b1) : quo[15:0];
    // Floor division: a negative quotient with a remainder rounds down.
    q_signed = neg_r ? -($signed({2'b00, quo}) + $signed({27'b0, rem != '0}))
                     : $signed({2'b00, quo});
    idx_sum  = q_signed + $signed({19'b0, ilo_r});
    if (idx_sum < 0) begin
      idx_res = '0;
    end else if (idx_sum > $signed({15'b0, aqia_pkg::INDEX_MAX})) begin
      idx_res = aqia_pkg::INDEX_MAX;
    end else begin
      idx_res = idx_sum[IDX_W-1:0];
    end
  end

  // Overall maximum and band.
  logic [IDX_W-1:0] all_max;
  logic [2:0]       cat;

  always_comb begin
    all_max = idx_r[0];
    for (int i = 1; i < aqia_pkg::NUM_IDX; i++) begin
      if (idx_r[i] > all_max) begin
        all_max = idx_r[i];
      end
    end
    if (all_max <= 13'd50) begin
      cat = aqia_pkg::CAT_GOOD;
    end else if (all_max <= 13'd100) begin
      cat = aqia_pkg::CAT_MODERATE;
    end else if (all_max <= 13'd150) begin
      cat = aqia_pkg::CAT_SENSITIVE;
    end else if (all_max <= 13'd200) begin
      cat = aqia_pkg::CAT_UNHEALTHY;
    end else if (all_max <= 13'd300) begin
      cat = aqia_pkg::CAT_VERY;
    end else begin
      cat = aqia_pkg::CAT_HAZARD;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= aqia_pkg::WINDOW_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < aqia_pkg::NUM_CH; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      if (cmd.accum && plausible) begin
        count_r <= count_inc;
        for (int i = 0; i < aqia_pkg::NUM_CH; i++) begin
          sum_r[i] <= sum_r[i] + add_val[i];
        end
      end else if (cmd.out_load) begin
        count_r <= '0;
        for (int i = 0; i < aqia_pkg::NUM_CH; i++) begin
          sum_r[i] <= '0;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= dvd_neg;
    end
    if (cmd.div_store) begin
      if (avg_step) begin
        avg_r[ch_sel] <= avg_res;
      end else begin
        idx_r[idx_sel] <= idx_res;
      end
    end
    if (cmd.idx_prep) begin
      num_r <= (prod <<< 1) + $signed({12'b0, span_c});
      den_r <= {span_c, 1'b0};
      ilo_r <= seg.ilo;
    end
    if (cmd.out_load) begin
      out_index_pm1       <= idx_r[aqia_pkg::CH_PM1];
      out_index_pm25      <= idx_r[aqia_pkg::CH_PM25];
      out_index_pm4       <= idx_r[aqia_pkg::CH_PM4];
      out_index_pm10      <= idx_r[aqia_pkg::CH_PM10];
      out_index_voc       <= idx_r[aqia_pkg::CH_VOC];
      out_overall_index   <= all_max;
      out_category        <= cat;
      out_avg_pm25        <= avg_r[aqia_pkg::CH_PM25];
      out_avg_pm10        <= avg_r[aqia_pkg::CH_PM10];
      out_avg_voc         <= avg_r[aqia_pkg::CH_VOC];
      out_avg_temperature <= avg_r[aqia_pkg::CH_TEMP];
      out_avg_humidity    <= avg_r[aqia_pkg::CH_HUM][13:0];
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/aqia_ctrl.sv
// Controller state machine: sequences accumulation, the twelve divisions and the result hand-off.
// Depends on aqia_pkg for the state, command and status types.
module aqia_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  aqia_pkg::aqia_sts_t sts,
  output aqia_pkg::aqia_cmd_t cmd
);

  aqia_pkg::aqia_state_t state_r, state_nxt;
  logic [3:0]            step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aqia_pkg::S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.step      = step_r;
    unique case (state_r)
      aqia_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accum = 1'b1;
          if (sts.trigger) begin
            step_nxt  = '0;
            state_nxt = aqia_pkg::S_DIV_LOAD;
          end
        end
      end
      aqia_pkg::S_DIV_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = aqia_pkg::S_DIV_RUN;
      end
      aqia_pkg::S_DIV_RUN: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          step_nxt      = step_r + 4'd1;
          if (step_r == aqia_pkg::STEP_LAST) begin
            state_nxt = aqia_pkg::S_OUT;
          end else if (step_r + 4'd1 >= aqia_pkg::STEP_FIRST_IDX) begin
            state_nxt = aqia_pkg::S_IDX_PREP;
          end else begin
            state_nxt = aqia_pkg::S_DIV_LOAD;
          end
        end
      end
      aqia_pkg::S_IDX_PREP: begin
        cmd.idx_prep = 1'b1;
        state_nxt    = aqia_pkg::S_DIV_LOAD;
      end
      aqia_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = aqia_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = aqia_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/air_quality_index_averager.sv
// Top level of the air quality index averager: controller and datapath.
// Depends on aqia_pkg, aqia_ctrl, aqia_datapath and aqia_div.
//
//   Channel   Ports                      Direction  Handshake
//   input     in_valid / in_ready + 7    in         valid/ready, one sample per item
//   result    out_valid / out_ready + 12 out        valid/ready, one result per item
//   config    cfg_wr_en / cfg_wr_data    in         write strobe, window length
//
// A sample that does not close a window leaves the controller idle. A sample
// that closes a window starts a sequence of twelve divisions on one shared
// radix-2 divider, each with its load and hand-off: seven averages, then five
// sub-indices with a setup step each. in_ready is low from then until the
// result enters the free output register. The result then sits there, and new
// samples are accepted while it waits to be taken. rst_n is synchronous and
// clears the sums, the sample count, the state and the window length (to two).
module air_quality_index_averager #(
  parameter int NUM_SEGMENTS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_pm1_raw,
  input  logic [15:0]        in_pm25_raw,
  input  logic [15:0]        in_pm4_raw,
  input  logic [15:0]        in_pm10_raw,
  input  logic [15:0]        in_humidity_raw,
  input  logic signed [15:0] in_temperature_raw,
  input  logic [15:0]        in_voc_raw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [12:0]        out_index_pm1,
  output logic [12:0]        out_index_pm25,
  output logic [12:0]        out_index_pm4,
  output logic [12:0]        out_index_pm10,
  output logic [12:0]        out_index_voc,
  output logic [12:0]        out_overall_index,
  output logic [2:0]         out_category,
  output logic [15:0]        out_avg_pm25,
  output logic [15:0]        out_avg_pm10,
  output logic [15:0]        out_avg_voc,
  output logic signed [15:0] out_avg_temperature,
  output logic [13:0]        out_avg_humidity
);

  // The controller issues one command word per cycle; the datapath reports
  // whether an accepted sample closes the window, when the divider is done,
  // and whether the output register can take a new result.
  aqia_pkg::aqia_cmd_t cmd;
  aqia_pkg::aqia_sts_t sts;

  aqia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the sums, the window register, the divider and the
  // output register with its valid flag.
  aqia_datapath #(
    .NUM_SEGMENTS (NUM_SEGMENTS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_pm1_raw          (in_pm1_raw),
    .in_pm25_raw         (in_pm25_raw),
    .in_pm4_raw          (in_pm4_raw),
    .in_pm10_raw         (in_pm10_raw),
    .in_humidity_raw     (in_humidity_raw),
    .in_temperature_raw  (in_temperature_raw),
    .in_voc_raw          (in_voc_raw),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_index_pm1       (out_index_pm1),
    .out_index_pm25      (out_index_pm25),
    .out_index_pm4       (out_index_pm4),
    .out_index_pm10      (out_index_pm10),
    .out_index_voc       (out_index_voc),
    .out_overall_index   (out_overall_index),
    .out_category        (out_category),
    .out_avg_pm25        (out_avg_pm25),
    .out_avg_pm10        (out_avg_pm10),
    .out_avg_voc         (out_avg_voc),
    .out_avg_temperature (out_avg_temperature),
    .out_avg_humidity    (out_avg_humidity)
  );

endmodule

### rtl/aqia_checker.sv
// Port-level checks of the air quality index averager, bound to the top level.
// Watches only the top level's ports; takes the category codes from aqia_pkg.
module aqia_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [12:0] out_index_pm1,
  input logic [12:0] out_index_pm25,
  input logic [12:0] out_index_pm4,
  input logic [12:0] out_index_pm10,
  input logic [12:0] out_index_voc,
  input logic [12:0] out_overall_index,
  input logic [2:0]  out_category
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_overall_index) && $stable(out_category))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_overall_index >= out_index_pm1 && out_overall_index >= out_index_pm25 &&
                  out_overall_index >= out_index_pm4 && out_overall_index >= out_index_pm10 &&
                  out_overall_index >= out_index_voc)
    else $error("overall index below a sub-index");

  a_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_overall_index <= 13'd50) == (out_category == aqia_pkg::CAT_GOOD)) &&
                  ((out_overall_index > 13'd300) == (out_category == aqia_pkg::CAT_HAZARD)))
    else $error("band does not match overall index");

endmodule

bind air_quality_index_averager aqia_checker u_aqia_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_index_pm1     (out_index_pm1),
  .out_index_pm25    (out_index_pm25),
  .out_index_pm4     (out_index_pm4),
  .out_index_pm10    (out_index_pm10),
  .out_index_voc     (out_index_voc),
  .out_overall_index (out_overall_index),
  .out_category      (out_category)
);
